### hw/rtl/rbdp_pkg.sv
`default_nettype none

package rbdp_pkg;

  // fixed field widths
  localparam int IDX_W    = 10;
  localparam int RANGE_W  = 11;
  localparam int REGION_W = 4;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  // size of the index space that the buffer_index field can name
  localparam int INDEX_SPACE = 1024;

  // defaults for top level parameters
  localparam int          NUM_BUFS_DEF  = 1024;
  localparam int unsigned COUNT_MAX_DEF = 65535;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEC   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_REGION  = 2'd2;

  // free stack request from the stage 1 decision logic
  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

  // free stack flags back to the stage 1 decision logic
  typedef struct packed {
    logic empty;
    logic full;
  } stack_stat_t;

endpackage

`default_nettype wire

### hw/rtl/rbdp_ram.sv
`default_nettype none

module rbdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/rbdp_free_stack.sv
`default_nettype none

module rbdp_free_stack
  import rbdp_pkg::*;
#(
  parameter int NUM_BUFS = NUM_BUFS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire stack_op_t        op,
  input  wire logic [IDX_W-1:0] push_data,
  output logic      [IDX_W-1:0] top,
  output stack_stat_t           stat
);

  localparam int AW = (NUM_BUFS > 1) ? $clog2(NUM_BUFS) : 1;
  localparam int DW = $clog2(NUM_BUFS + 1);

  // top entry lives in a register, entries below it in the ram;
  // the ram read port always prefetches the entry under the top
  logic [DW-1:0]    depth;
  logic [DW-1:0]    depth_next;
  logic [DW-1:0]    rd_ptr;
  logic [IDX_W-1:0] top_next;
  logic             byp_valid;
  logic [IDX_W-1:0] byp;
  logic [IDX_W-1:0] rdata;
  logic [IDX_W-1:0] below;
  logic [DW-1:0]    wr_ptr;
  logic             do_push;
  logic             do_pop;
  logic             we;

  assign stat.empty = (depth == '0);
  assign stat.full  = (depth == DW'(NUM_BUFS));

  assign do_push = op.push && !stat.full;
  assign do_pop  = op.pop && !stat.empty;

  // entry just written by a push is not yet on the read port in the next cycle, so the bypass supplies it
  assign below = byp_valid ? byp : rdata;

  always_comb begin
    depth_next = depth;
    top_next   = top;
    if (do_push) begin
      depth_next = depth + DW'(1);
      top_next   = push_data;
    end else if (do_pop) begin
      depth_next = depth - DW'(1);
      top_next   = below;
    end
  end

  assign we     = do_push && !stat.empty;
  assign wr_ptr = depth - DW'(1);
  assign rd_ptr = depth_next - DW'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      byp_valid <= 1'b0;
    end else begin
      depth     <= depth_next;
      byp_valid <= do_push;
    end
    top <= top_next;
    byp <= top;
  end

  rbdp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_BUFS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_ptr[AW-1:0]),
    .wdata (top),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

### hw/rtl/refcounted_buffer_descriptor_pool_core.sv
`default_nettype none

// path: input beat to result beat via the stage 1 item register (ledger read), then the result register
// throughput: one item per cycle while out_ready is held high; the ledger ram read/write pair
//   and the free stack prefetch port each serve one item per cycle
// reset: counts and change bits are cleared by a pass over all NUM_BUFS entries after rst,
//   one entry per cycle; in_ready stays low until it ends, cfg writes are taken throughout
module refcounted_buffer_descriptor_pool_core
  import rbdp_pkg::*;
#(
  parameter int          NUM_BUFS  = NUM_BUFS_DEF,
  parameter int unsigned COUNT_MAX = COUNT_MAX_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [RANGE_W-1:0]   cfg_data,
  // requests
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [KIND_W-1:0]    kind,
  input  wire logic [IDX_W-1:0]     buffer_index,
  input  wire logic [REGION_W-1:0]  owner_region,
  // results
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [STATUS_W-1:0]       status,
  output logic [IDX_W-1:0]          result_index,
  output logic                      released,
  output logic                      change_toggled,
  output logic                      change_bit
);

  localparam int AW = (NUM_BUFS > 1) ? $clog2(NUM_BUFS) : 1;
  localparam int CW = $clog2(64'(COUNT_MAX) + 64'd1);
  localparam int LW = CW + 1;   // ledger entry: change bit over count
  localparam int FRESH_LIM = (NUM_BUFS < INDEX_SPACE) ? NUM_BUFS : INDEX_SPACE;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [RANGE_W-1:0]  range_start;
  logic [REGION_W-1:0] own_region;
  logic [RANGE_W-1:0]  fresh_next;       // next fresh index counter (counts down)
  logic [RANGE_W-1:0]  fresh_reload;
  logic                cfg_acc;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // writing range_end reloads the fresh counter, clipped to the smaller of the store size and the index space;
  // range_end itself is not kept
  assign fresh_reload = (cfg_data > RANGE_W'(FRESH_LIM)) ? RANGE_W'(FRESH_LIM) : cfg_data;

  // ---------------------------------------------------------------------------
  // clearing pass over the ledger after reset
  // ---------------------------------------------------------------------------
  logic          clr_active;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(NUM_BUFS - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: item register, ledger read data comes back here
  // ---------------------------------------------------------------------------
  logic                s1_valid;
  logic [KIND_W-1:0]   s1_kind;
  logic [IDX_W-1:0]    s1_idx;
  logic [REGION_W-1:0] s1_owner;
  logic                s1_fire;
  logic                in_acc;

  // stage 1 moves whenever the result register is free or being drained
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clr_active && (!s1_valid || s1_fire);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
    if (in_acc) begin
      s1_kind  <= kind;
      s1_idx   <= buffer_index;
      s1_owner <= owner_region;
    end
  end

  // index field to ledger address, widened or narrowed to the store size
  logic [IDX_W+AW-1:0] in_idx_ext;
  logic [IDX_W+AW-1:0] s1_idx_ext;
  logic [AW-1:0]       s1_addr;
  logic                s1_in_store;

  assign in_idx_ext  = {{AW{1'b0}}, buffer_index};
  assign s1_idx_ext  = {{AW{1'b0}}, s1_idx};
  assign s1_addr     = s1_idx_ext[AW-1:0];
  assign s1_in_store = (32'(s1_idx) < 32'(NUM_BUFS));

  // ---------------------------------------------------------------------------
  // ledger ram: per-buffer reference count and change bit
  // ---------------------------------------------------------------------------
  logic          led_we;
  logic [AW-1:0] led_waddr;
  logic [LW-1:0] led_wdata;
  logic [AW-1:0] led_raddr;
  logic [LW-1:0] led_rdata;

  // item write from stage 1 (gated by s1_fire below)
  logic          upd_we;
  logic [LW-1:0] upd_data;

  // last item write, forwarded to the item right behind it (ram read is read-first)
  logic          lw_valid;
  logic [AW-1:0] lw_addr;
  logic [LW-1:0] lw_data;
  logic [LW-1:0] led_cur;
  logic [CW-1:0] cur_count;
  logic          cur_change;

  // hold the read address on the stalled item so the data stays current
  assign led_raddr = in_acc ? in_idx_ext[AW-1:0] : s1_addr;

  assign led_we    = clr_active || (s1_fire && upd_we);
  assign led_waddr = clr_active ? clr_addr : s1_addr;
  assign led_wdata = clr_active ? '0 : upd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else begin
      lw_valid <= s1_fire && upd_we;
    end
    lw_addr <= s1_addr;
    lw_data <= upd_data;
  end

  assign led_cur    = (lw_valid && (lw_addr == s1_addr)) ? lw_data : led_rdata;
  assign cur_count  = led_cur[CW-1:0];
  assign cur_change = led_cur[CW];

  rbdp_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_BUFS)
  ) u_ledger_ram (
    .clk   (clk),
    .we    (led_we),
    .waddr (led_waddr),
    .wdata (led_wdata),
    .raddr (led_raddr),
    .rdata (led_rdata)
  );

  // ---------------------------------------------------------------------------
  // free stack of released indexes
  // ---------------------------------------------------------------------------
  stack_op_t        stk_op;
  stack_op_t        stk_req;
  stack_stat_t      stk_stat;
  logic [IDX_W-1:0] stk_top;

  assign stk_op.push = s1_fire && stk_req.push;
  assign stk_op.pop  = s1_fire && stk_req.pop;

  rbdp_free_stack #(
    .NUM_BUFS (NUM_BUFS)
  ) u_free_stack (
    .clk       (clk),
    .rst       (rst),
    .op        (stk_op),
    .push_data (s1_idx),
    .top       (stk_top),
    .stat      (stk_stat)
  );

  // ---------------------------------------------------------------------------
  // stage 1 decision: result fields and state updates
  // ---------------------------------------------------------------------------
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_index;
  logic                res_released;
  logic                res_toggled;
  logic                res_change;
  logic                fresh_take;
  logic [RANGE_W-1:0]  fresh_dec;
  logic [CW-1:0]       new_count;
  logic                new_change;

  assign fresh_dec = fresh_next - RANGE_W'(1);

  always_comb begin
    res_status   = ST_OK;
    res_index    = '0;
    res_released = 1'b0;
    res_toggled  = 1'b0;
    res_change   = 1'b0;
    stk_req      = '0;
    fresh_take   = 1'b0;
    upd_we       = 1'b0;
    new_count    = cur_count;
    new_change   = cur_change;
    case (s1_kind)
      KIND_ALLOC: begin
        if (!stk_stat.empty) begin
          // most recently released index first
          stk_req.pop = 1'b1;
          res_index   = stk_top;
        end else if (fresh_next > range_start) begin
          fresh_take = 1'b1;
          res_index  = fresh_dec[IDX_W-1:0];
        end else begin
          res_status = ST_NO_FREE;
        end
      end
      KIND_INC: begin
        res_index = s1_idx;
        if (s1_in_store) begin
          upd_we = 1'b1;
          if (cur_count >= CW'(COUNT_MAX)) begin
            res_status = ST_OVERFLOW;
          end else begin
            new_count = cur_count + CW'(1);
          end
          res_change = cur_change;
        end
      end
      KIND_DEC: begin
        res_index = s1_idx;
        if (s1_in_store) begin
          upd_we = 1'b1;
          if (cur_count != '0) begin
            new_count = cur_count - CW'(1);
          end else if (s1_owner == own_region) begin
            // own buffer back to the pool; dropped when the stack is full
            res_released = 1'b1;
            stk_req.push = 1'b1;
          end else begin
            // foreign buffer: flip its change bit
            new_change  = !cur_change;
            res_toggled = 1'b1;
          end
          res_change = new_change;
        end
      end
      default: begin
        // unused kind: no state change, all-zero result
      end
    endcase
    upd_data = {new_change, new_count};
  end

  // ---------------------------------------------------------------------------
  // config registers and fresh counter
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      range_start <= '0;
      own_region  <= '0;
      fresh_next  <= RANGE_W'(FRESH_LIM);
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index)
          REG_RANGE_START: range_start <= cfg_data;
          REG_RANGE_END:   fresh_next  <= fresh_reload;
          REG_OWN_REGION:  own_region  <= cfg_data[REGION_W-1:0];
          default: begin
          end
        endcase
      end
      if (s1_fire && fresh_take) begin
        fresh_next <= fresh_dec;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire) begin
      status         <= res_status;
      result_index   <= res_index;
      released       <= res_released;
      change_toggled <= res_toggled;
      change_bit     <= res_change;
    end
  end

endmodule

`default_nettype wire
